@@ rtl/core/ecef_to_geodetic_top_defines.svh @@
// Assertion macros for the ECEF to geodetic block
`ifndef ECEF_TO_GEODETIC_TOP_DEFINES_SVH
`define ECEF_TO_GEODETIC_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define E2G_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define E2G_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/e2g_pkg.sv @@
// Constants and the arctangent table function for the ECEF to geodetic block
`timescale 1ns / 1ps
package e2g_pkg;

  localparam logic [63:0] QUARTER_PI_Q60 = 64'h0C90FDAA22168C23;
  localparam logic [63:0] HALF_PI_Q60    = 64'h1921FB54442D1846;
  localparam logic [63:0] PI_Q60         = 64'h3243F6A8885A308D;
  localparam logic [63:0] ONE_Q60        = 64'h1000000000000000;
  localparam logic [63:0] KINV_Q32       = 64'd2608131496;
  localparam logic [63:0] UNIT_X0        = 64'd2608131496 << 28;
  localparam logic [63:0] SEMI_MAJOR_01MM = 64'd63781370;
  localparam logic [63:0] SEMI_MINOR_01MM = 64'd63567523;
  localparam logic [63:0] SEMI_MINOR_MM   = 64'd6356752300;
  localparam logic [63:0] A2_01 = SEMI_MAJOR_01MM * SEMI_MAJOR_01MM;
  localparam logic [63:0] C2_01 = A2_01 - SEMI_MINOR_01MM * SEMI_MINOR_01MM;
  localparam logic [63:0] EPB_Q60 = (C2_01 << 19) / (64'd5 * SEMI_MINOR_01MM);
  localparam logic [63:0] EA_Q60  = (C2_01 << 19) / (64'd5 * SEMI_MAJOR_01MM);
  localparam logic [63:0] E7_PER_RAD_Q92 = 64'd572957795 * 64'd4294967296 + 64'd561881403;
  localparam logic [31:0] RECIP5 = 32'hCCCCCCCD;
  localparam logic [31:0] MUL1638 = 32'd1638;
  localparam logic signed [63:0] LAT_LIM = 64'sd900000000;
  localparam logic signed [63:0] LON_LIM = 64'sd1800000000;
  localparam logic signed [63:0] H_MAX = 64'sd137438953471;
  localparam logic signed [63:0] H_MIN = -64'sd137438953472;
  localparam logic signed [63:0] HALF20 = 64'sd524288;

  // arctan(2^-i) in Q60 by the truncated odd power series
  function automatic logic [63:0] atan_q60(input int i);
    logic [63:0] sum;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;
    logic [63:0] rem;
    int m;
    int k;
    int b;
    sum = 64'd0;
    if (i == 0) begin
      sum = QUARTER_PI_Q60;
    end else begin
      for (k = 0; k < 31; k++) begin
        m = i * (2 * k + 1);
        if (m <= 60) begin
          num = 64'd1 << (60 - m);
          den = 64'(2 * k + 1);
          quo = 64'd0;
          rem = 64'd0;
          for (b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
              rem = rem - den;
              quo[b] = 1'b1;
            end
          end
          if ((k & 1) != 0) sum = sum - quo;
          else sum = sum + quo;
        end
      end
    end
    return sum;
  endfunction

endpackage

@@ rtl/core/ecef_to_geodetic_top.sv @@
// Top level of the ECEF to WGS84 geodetic conversion pipeline
`timescale 1ns / 1ps
`include "ecef_to_geodetic_top_defines.svh"
// Usage:
//   Drive ecef_x_mm_i, ecef_y_mm_i, ecef_z_mm_i and raise start for one
//   cycle per point. busy stays low, so a point is taken at every edge
//   where start is high, one per clock.
//   Each result appears on latitude_e7_o, longitude_e7_o, height_mm_o and
//   at_origin_o for exactly one cycle, marked by done_o, in input order.
//   Each point passes through three chained CORDIC pipelines of
//   ANGLE_ITERATIONS stages each, the 32-stage square root and the
//   registered multipliers between them.
//   Throughput is one point per cycle.
//   The Earth centre returns zeros with at_origin_o set; a point on the
//   polar axis returns +-90 degrees and |z| minus the semi-minor axis.
//   Reset clears every valid bit in flight; no result is produced for a
//   point accepted before reset. The receiver cannot stall, so nothing
//   is held back and nothing is dropped.
module ecef_to_geodetic_top #(
  parameter int unsigned ANGLE_ITERATIONS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [37:0] ecef_x_mm_i,
  input  logic signed [37:0] ecef_y_mm_i,
  input  logic signed [37:0] ecef_z_mm_i,
  output logic               done_o,
  output logic signed [30:0] latitude_e7_o,
  output logic signed [31:0] longitude_e7_o,
  output logic signed [37:0] height_mm_o,
  output logic               at_origin_o
);
  import e2g_pkg::*;

  localparam int unsigned N = ANGLE_ITERATIONS;

  logic signed [63:0] xs, ys, zs;
  logic signed [63:0] x0_q, y0_q, base_q, zq_q;
  logic               org_q, pol_q, vld_q;
  logic signed [37:0] z_q;

  assign busy = 1'b0;

  always_comb begin
    xs = {{6{ecef_x_mm_i[37]}}, ecef_x_mm_i, 20'd0};
    ys = {{6{ecef_y_mm_i[37]}}, ecef_y_mm_i, 20'd0};
    zs = {{6{ecef_z_mm_i[37]}}, ecef_z_mm_i, 20'd0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (xs[63]) begin
      x0_q   <= -xs;
      y0_q   <= -ys;
      base_q <= ys[63] ? 64'sd0 - $signed(PI_Q60) : $signed(PI_Q60);
    end else begin
      x0_q   <= xs;
      y0_q   <= ys;
      base_q <= 64'sd0;
    end
    zq_q  <= zs;
    z_q   <= ecef_z_mm_i;
    org_q <= (ecef_x_mm_i == '0) && (ecef_y_mm_i == '0) && (ecef_z_mm_i == '0);
    pol_q <= (ecef_x_mm_i == '0) && (ecef_y_mm_i == '0) && (ecef_z_mm_i != '0);
  end

  // longitude and horizontal radius
  logic signed [63:0] xl, lon_ang, xcl, p;
  e2g_cordic #(.N(N)) u_lon (
    .clk_i, .x_i(x0_q), .y_i(y0_q), .ang_i(base_q),
    .x_o(xl), .y_o(), .ang_o(lon_ang), .c_o(), .s_o()
  );
  assign xcl = xl[63] ? 64'sd0 : xl;
  e2g_mul #(.SHIFT(32), .SGN(1'b0), .CLAMP(1'b0)) u_p (
    .clk_i, .a_i(xcl), .b_i(KINV_Q32), .r_o(p)
  );

  // auxiliary angle theta
  logic signed [63:0] zq1, bp, az, ct, st, ctst_c, ctst_s;
  e2g_dly #(.WIDTH(64), .DEPTH(N + 2)) u_zd1 (.clk_i, .rst_ni, .d_i(zq_q), .q_o(zq1));
  e2g_mul #(.SHIFT(26), .SGN(1'b0), .CLAMP(1'b0)) u_bp (
    .clk_i, .a_i(p), .b_i(SEMI_MINOR_01MM), .r_o(bp)
  );
  e2g_mul #(.SHIFT(26), .SGN(1'b1), .CLAMP(1'b1)) u_az (
    .clk_i, .a_i(zq1), .b_i(SEMI_MAJOR_01MM), .r_o(az)
  );
  e2g_cordic #(.N(N)) u_theta (
    .clk_i, .x_i(bp), .y_i(az), .ang_i(64'sd0),
    .x_o(), .y_o(), .ang_o(), .c_o(ct), .s_o(st)
  );

  // cubes and Bowring terms
  logic signed [63:0] s2a, c2a, s3, c3, es, ec;
  e2g_dly #(.WIDTH(128), .DEPTH(2)) u_csd (
    .clk_i, .rst_ni, .d_i({ct, st}), .q_o({ctst_c, ctst_s})
  );
  e2g_mul #(.SHIFT(60)) u_sqs (.clk_i, .a_i(st), .b_i(st), .r_o(s2a));
  e2g_mul #(.SHIFT(60)) u_sqc (.clk_i, .a_i(ct), .b_i(ct), .r_o(c2a));
  e2g_mul #(.SHIFT(60)) u_cbs (.clk_i, .a_i(s2a), .b_i(ctst_s), .r_o(s3));
  e2g_mul #(.SHIFT(60)) u_cbc (.clk_i, .a_i(c2a), .b_i(ctst_c), .r_o(c3));
  e2g_mul #(.SHIFT(60)) u_es (.clk_i, .a_i(EPB_Q60), .b_i(s3), .r_o(es));
  e2g_mul #(.SHIFT(60)) u_ec (.clk_i, .a_i(EA_Q60), .b_i(c3), .r_o(ec));

  logic signed [63:0] zq2, p2, num_q, den_q;
  e2g_dly #(.WIDTH(64), .DEPTH(2 * N + 10)) u_zd2 (.clk_i, .rst_ni, .d_i(zq_q), .q_o(zq2));
  e2g_dly #(.WIDTH(64), .DEPTH(N + 8)) u_pd2 (.clk_i, .rst_ni, .d_i(p), .q_o(p2));

  always_ff @(posedge clk_i) begin
    num_q <= zq2 + es;
    den_q <= p2 - ec;
  end

  // latitude
  logic signed [63:0] ang3, cp3, sp3, lat_sel_q, cp_q, sp_q;
  logic               deep_d, npos_d, nneg_d;
  e2g_cordic #(.N(N)) u_lat (
    .clk_i, .x_i(den_q), .y_i(num_q), .ang_i(64'sd0),
    .x_o(), .y_o(), .ang_o(ang3), .c_o(cp3), .s_o(sp3)
  );
  e2g_dly #(.WIDTH(3), .DEPTH(N)) u_sgn (
    .clk_i, .rst_ni,
    .d_i({den_q <= 64'sd0, num_q > 64'sd0, num_q < 64'sd0}),
    .q_o({deep_d, npos_d, nneg_d})
  );

  always_ff @(posedge clk_i) begin
    if (!deep_d) begin
      lat_sel_q <= ang3;
      cp_q      <= cp3;
      sp_q      <= sp3;
    end else if (npos_d) begin
      lat_sel_q <= HALF_PI_Q60;
      cp_q      <= 64'sd0;
      sp_q      <= ONE_Q60;
    end else if (nneg_d) begin
      lat_sel_q <= 64'sd0 - $signed(HALF_PI_Q60);
      cp_q      <= 64'sd0;
      sp_q      <= 64'sd0 - $signed(ONE_Q60);
    end else begin
      lat_sel_q <= 64'sd0;
      cp_q      <= ONE_Q60;
      sp_q      <= 64'sd0;
    end
  end

  // ellipsoid radius term a*sqrt(1 - e^2 sin^2)
  logic [63:0] s2v, c2s, rad_q, prod_q, v1638_q;
  logic [31:0] v, v_q;
  logic [29:0] q5;
  logic [34:0] r5;
  logic signed [63:0] aw_q;
  e2g_mul #(.SHIFT(60), .SGN(1'b1), .CLAMP(1'b0)) u_s2 (
    .clk_i, .a_i(sp_q), .b_i(sp_q), .r_o(s2v)
  );
  e2g_mul #(.SHIFT(60), .SGN(1'b0), .CLAMP(1'b0)) u_c2s (
    .clk_i, .a_i(C2_01), .b_i(s2v), .r_o(c2s)
  );

  always_ff @(posedge clk_i) begin
    rad_q <= (c2s < A2_01) ? (A2_01 - c2s) << 12 : 64'd0;
  end

  e2g_sqrt u_sqrt (.clk_i, .n_i(rad_q), .r_o(v));

  always_ff @(posedge clk_i) begin
    prod_q  <= v * RECIP5;
    v1638_q <= v * MUL1638;
    v_q     <= v;
  end

  always_comb begin
    q5 = prod_q[63:34];
    r5 = {3'd0, v_q} - 35'(q5) * 35'd5;
  end

  always_ff @(posedge clk_i) begin
    aw_q <= $signed(v1638_q + {33'd0, q5, 1'b0} + 64'(r5 >= 35'd3));
  end

  // height before rounding
  logic signed [63:0] p3, zq3, pc, zsv, psum_q, psum_d, hq_q;
  e2g_dly #(.WIDTH(64), .DEPTH(2 * N + 10)) u_pd3 (.clk_i, .rst_ni, .d_i(p), .q_o(p3));
  e2g_dly #(.WIDTH(64), .DEPTH(3 * N + 12)) u_zd3 (.clk_i, .rst_ni, .d_i(zq_q), .q_o(zq3));
  e2g_mul #(.SHIFT(60)) u_pc (.clk_i, .a_i(p3), .b_i(cp_q), .r_o(pc));
  e2g_mul #(.SHIFT(60)) u_zs (.clk_i, .a_i(zq3), .b_i(sp_q), .r_o(zsv));

  always_ff @(posedge clk_i) begin
    psum_q <= pc + zsv;
  end

  e2g_dly #(.WIDTH(64), .DEPTH(36)) u_psd (.clk_i, .rst_ni, .d_i(psum_q), .q_o(psum_d));

  always_ff @(posedge clk_i) begin
    hq_q <= psum_d - aw_q;
  end

  // angles to 1e-7 degree
  logic signed [63:0] latm, lonm, latm_d, lonm_d;
  e2g_mul #(.SHIFT(92)) u_latm (.clk_i, .a_i(lat_sel_q), .b_i(E7_PER_RAD_Q92), .r_o(latm));
  e2g_mul #(.SHIFT(92)) u_lonm (.clk_i, .a_i(lon_ang), .b_i(E7_PER_RAD_Q92), .r_o(lonm));
  e2g_dly #(.WIDTH(64), .DEPTH(38)) u_latd (.clk_i, .rst_ni, .d_i(latm), .q_o(latm_d));
  e2g_dly #(.WIDTH(64), .DEPTH(2 * N + 50)) u_lond (
    .clk_i, .rst_ni, .d_i(lonm), .q_o(lonm_d)
  );

  // special cases and beat strobe
  logic               org_d, pol_d, vld_d;
  logic signed [37:0] z_d;
  e2g_dly #(.WIDTH(40), .DEPTH(3 * N + 52)) u_flg (
    .clk_i, .rst_ni, .d_i({org_q, pol_q, z_q}), .q_o({org_d, pol_d, z_d})
  );
  e2g_dly #(.WIDTH(1), .DEPTH(3 * N + 53)) u_vld (
    .clk_i, .rst_ni, .d_i(vld_q), .q_o(vld_d)
  );
  assign done_o = vld_d;

  logic signed [63:0] hr, zx, zabs, hsel, hsat, latc, lonc;

  always_comb begin
    hr   = hq_q[63] ? 64'sd0 - ((64'sd0 - hq_q + HALF20) >>> 20) : ((hq_q + HALF20) >>> 20);
    zx   = {{26{z_d[37]}}, z_d};
    zabs = zx[63] ? -zx : zx;
    hsel = pol_d ? zabs - $signed(SEMI_MINOR_MM) : hr;
    if (hsel > H_MAX) hsat = H_MAX;
    else if (hsel < H_MIN) hsat = H_MIN;
    else hsat = hsel;
    if (pol_d) latc = z_d[37] ? -LAT_LIM : LAT_LIM;
    else if (latm_d > LAT_LIM) latc = LAT_LIM;
    else if (latm_d < -LAT_LIM) latc = -LAT_LIM;
    else latc = latm_d;
    if (pol_d) lonc = 64'sd0;
    else if (lonm_d > LON_LIM) lonc = LON_LIM;
    else if (lonm_d < -LON_LIM) lonc = -LON_LIM;
    else lonc = lonm_d;
  end

  always_ff @(posedge clk_i) begin
    if (org_d) begin
      latitude_e7_o  <= '0;
      longitude_e7_o <= '0;
      height_mm_o    <= '0;
      at_origin_o    <= 1'b1;
    end else begin
      latitude_e7_o  <= latc[30:0];
      longitude_e7_o <= lonc[31:0];
      height_mm_o    <= hsat[37:0];
      at_origin_o    <= 1'b0;
    end
  end

  `E2G_ASSERT_IMPL(a_origin_zero, done_o && at_origin_o, (latitude_e7_o == '0) && (longitude_e7_o == '0) && (height_mm_o == '0), "origin beat carries nonzero fields")
  `E2G_ASSERT_IMPL(a_lat_range, done_o, (latitude_e7_o <= 31'sd900000000) && (latitude_e7_o >= -31'sd900000000), "latitude out of range")
  `E2G_ASSERT_IMPL(a_lon_range, done_o, (longitude_e7_o <= 32'sd1800000000) && (longitude_e7_o >= -32'sd1800000000), "longitude out of range")
  `E2G_ASSERT_NEXT(a_no_busy, start, !busy, "block reports busy")
endmodule

@@ rtl/core/e2g_dly.sv @@
// Fixed-depth delay line for data and valid bits
`timescale 1ns / 1ps
module e2g_dly #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);
  logic [WIDTH-1:0] sr_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(DEPTH); i++) sr_q[i] <= '0;
    end else begin
      sr_q[0] <= d_i;
      for (int i = 1; i < int'(DEPTH); i++) sr_q[i] <= sr_q[i-1];
    end
  end

  assign q_o = sr_q[DEPTH-1];
endmodule

@@ rtl/core/e2g_mul.sv @@
// Two-stage 64x64 multiplier with rounded right shift and optional clamp
`timescale 1ns / 1ps
module e2g_mul #(
  parameter int unsigned SHIFT = 60,
  parameter bit          SGN   = 1'b1,
  parameter bit          CLAMP = 1'b1
) (
  input  logic        clk_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] r_o
);
  import e2g_pkg::*;

  logic [63:0]  ma, mb, mag, r_d;
  logic         neg;
  logic [63:0]  p00_q, p01_q, p10_q, p11_q;
  logic         neg_q;
  logic [127:0] sum;

  always_comb begin
    ma  = (SGN && a_i[63]) ? 64'd0 - a_i : a_i;
    mb  = (SGN && b_i[63]) ? 64'd0 - b_i : b_i;
    neg = SGN && (a_i[63] ^ b_i[63]);
  end

  always_ff @(posedge clk_i) begin
    p00_q <= ma[31:0]  * mb[31:0];
    p01_q <= ma[31:0]  * mb[63:32];
    p10_q <= ma[63:32] * mb[31:0];
    p11_q <= ma[63:32] * mb[63:32];
    neg_q <= neg;
  end

  always_comb begin
    sum = {p11_q, 64'd0} + {32'd0, p01_q, 32'd0} + {32'd0, p10_q, 32'd0}
        + {64'd0, p00_q} + (128'd1 << (SHIFT - 1));
    mag = 64'(sum >> SHIFT);
    if (CLAMP && (mag > (64'd1 << 62))) mag = 64'd1 << 62;
    r_d = neg_q ? 64'd0 - mag : mag;
  end

  always_ff @(posedge clk_i) begin
    r_o <= r_d;
  end
endmodule

@@ rtl/core/e2g_cordic.sv @@
// Pipelined CORDIC vectoring with a lockstep unit-vector replay lane
`timescale 1ns / 1ps
module e2g_cordic #(
  parameter int unsigned N = 32
) (
  input  logic               clk_i,
  input  logic signed [63:0] x_i,
  input  logic signed [63:0] y_i,
  input  logic signed [63:0] ang_i,
  output logic signed [63:0] x_o,
  output logic signed [63:0] y_o,
  output logic signed [63:0] ang_o,
  output logic signed [63:0] c_o,
  output logic signed [63:0] s_o
);
  import e2g_pkg::*;

  logic signed [63:0] x_q [N];
  logic signed [63:0] y_q [N];
  logic signed [63:0] a_q [N];
  logic signed [63:0] c_q [N];
  logic signed [63:0] s_q [N];

  for (genvar g = 0; g < int'(N); g++) begin : g_stage
    localparam logic signed [63:0] Tab = atan_q60(g);
    logic signed [63:0] xi, yi, ai, ci, si;
    if (g == 0) begin : g_first
      assign xi = x_i;
      assign yi = y_i;
      assign ai = ang_i;
      assign ci = UNIT_X0;
      assign si = 64'sd0;
    end else begin : g_next
      assign xi = x_q[g-1];
      assign yi = y_q[g-1];
      assign ai = a_q[g-1];
      assign ci = c_q[g-1];
      assign si = s_q[g-1];
    end
    always_ff @(posedge clk_i) begin
      if (!yi[63]) begin
        x_q[g] <= xi + (yi >>> g);
        y_q[g] <= yi - (xi >>> g);
        a_q[g] <= ai + Tab;
        c_q[g] <= ci - (si >>> g);
        s_q[g] <= si + (ci >>> g);
      end else begin
        x_q[g] <= xi - (yi >>> g);
        y_q[g] <= yi + (xi >>> g);
        a_q[g] <= ai - Tab;
        c_q[g] <= ci + (si >>> g);
        s_q[g] <= si - (ci >>> g);
      end
    end
  end

  assign x_o   = x_q[N-1];
  assign y_o   = y_q[N-1];
  assign ang_o = a_q[N-1];
  assign c_o   = c_q[N-1];
  assign s_o   = s_q[N-1];
endmodule

@@ rtl/core/e2g_sqrt.sv @@
// Pipelined 64-bit integer square root, one result bit per stage
`timescale 1ns / 1ps
module e2g_sqrt (
  input  logic        clk_i,
  input  logic [63:0] n_i,
  output logic [31:0] r_o
);
  logic [63:0] n_q [32];
  logic [63:0] r_q [32];

  for (genvar g = 0; g < 32; g++) begin : g_stage
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * g);
    logic [63:0] ni, ri, t;
    if (g == 0) begin : g_first
      assign ni = n_i;
      assign ri = 64'd0;
    end else begin : g_next
      assign ni = n_q[g-1];
      assign ri = r_q[g-1];
    end
    assign t = ri + Bit;
    always_ff @(posedge clk_i) begin
      if (ni >= t) begin
        n_q[g] <= ni - t;
        r_q[g] <= (ri >> 1) + Bit;
      end else begin
        n_q[g] <= ni;
        r_q[g] <= ri >> 1;
      end
    end
  end

  assign r_o = r_q[31][31:0];
endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the ECEF to WGS84 geodetic conversion pipeline
`timescale 1ns / 1ps
module testbench;
  import e2g_pkg::*;

  localparam int          N_ITER      = 32;
  localparam int          LATENCY     = 3 * N_ITER + 54;
  localparam int          N_RANDOM    = 1030;
  localparam longint      CYCLE_LIMIT = 600000;
  localparam longint      SURF_SPAN   = 64'sd8000000000;
  localparam longint      FIELD_MAX   = 64'sd137438953471;
  localparam longint      FIELD_MIN   = -64'sd137438953472;

  typedef struct {
    logic signed [30:0] lat;
    logic signed [31:0] lon;
    logic signed [37:0] hgt;
    logic               origin;
  } geo_t;

  class geo_scoreboard;
    geo_t   pending_geo[$];
    longint atan_q60[64];
    int     errors;

    function new();
      longint unsigned t;
      longint sum;
      int m;
      errors = 0;
      atan_q60[0] = QUARTER_PI_Q60;
      for (int i = 1; i < 64; i++) begin
        sum = 0;
        for (int k = 0; k < 64; k++) begin
          m = i * (2 * k + 1);
          if (m > 60) break;
          t = (64'd1 << (60 - m)) / longint'(2 * k + 1);
          sum = (k & 1) ? sum - longint'(t) : sum + longint'(t);
        end
        atan_q60[i] = sum;
      end
    endfunction

    function longint unsigned mul_shr_u(longint unsigned a, longint unsigned b, int s);
      logic [127:0] w;
      w = {64'd0, a} * {64'd0, b};
      w = w + (128'd1 << (s - 1));
      w = w >> s;
      return w[63:0];
    endfunction

    function longint mul_shr_s(longint a, longint b, int s);
      logic neg;
      longint unsigned ua, ub, r;
      neg = (a < 0) != (b < 0);
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      r = mul_shr_u(ua, ub, s);
      if (r > (64'd1 << 62)) r = 64'd1 << 62;
      return neg ? -longint'(r) : longint'(r);
    endfunction

    function longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned res, bits;
      res = 0;
      bits = 64'd1 << 62;
      while (bits > n) bits = bits >> 2;
      while (bits != 0) begin
        if (n >= res + bits) begin
          n = n - (res + bits);
          res = (res >> 1) + bits;
        end else begin
          res = res >> 1;
        end
        bits = bits >> 2;
      end
      return res;
    endfunction

    function longint rotate_to_axis(inout longint vx, inout longint vy,
                                    output logic [63:0] dir);
      longint ang, nx;
      ang = 0;
      dir = '0;
      for (int i = 0; i < N_ITER; i++) begin
        dir[i] = (vy >= 0);
        if (dir[i]) begin
          nx = vx + (vy >>> i);
          vy = vy - (vx >>> i);
          ang = ang + atan_q60[i];
        end else begin
          nx = vx - (vy >>> i);
          vy = vy + (vx >>> i);
          ang = ang - atan_q60[i];
        end
        vx = nx;
      end
      return ang;
    endfunction

    function void replay_unit(logic [63:0] dir, output longint c, output longint s);
      longint nx;
      c = longint'(KINV_Q32 << 28);
      s = 0;
      for (int i = 0; i < N_ITER; i++) begin
        if (dir[i]) begin
          nx = c - (s >>> i);
          s = s + (c >>> i);
        end else begin
          nx = c + (s >>> i);
          s = s - (c >>> i);
        end
        c = nx;
      end
    endfunction

    function longint to_e7(longint r, longint lim);
      longint v;
      v = mul_shr_s(r, longint'(E7_PER_RAD_Q92), 92);
      return v > lim ? lim : (v < -lim ? -lim : v);
    endfunction

    function geo_t convert(longint x, longint y, longint z);
      geo_t g;
      logic [63:0] dir;
      longint lat, lon, h, xq, yq, zq, base, p, bp, az, ct, st, c3, s3;
      longint num, den, cp, sp, hq, aw, lat_rad, asp, dummy, half;
      longint unsigned s2, c2s, v;
      g.origin = 1'b0;
      lon = 0;
      if (x == 0 && y == 0 && z == 0) begin
        g.lat = '0;
        g.lon = '0;
        g.hgt = '0;
        g.origin = 1'b1;
        return g;
      end
      if (x == 0 && y == 0) begin
        lat = z > 0 ? LAT_LIM : -LAT_LIM;
        h = (z > 0 ? z : -z) - longint'(SEMI_MINOR_MM);
      end else begin
        xq = x * (64'sd1 << 20);
        yq = y * (64'sd1 << 20);
        zq = z * (64'sd1 << 20);
        base = 0;
        if (xq < 0) begin
          base = yq >= 0 ? longint'(PI_Q60) : -longint'(PI_Q60);
          xq = -xq;
          yq = -yq;
        end
        lon = base + rotate_to_axis(xq, yq, dir);
        if (xq < 0) xq = 0;
        p = longint'(mul_shr_u(xq, KINV_Q32, 32));
        bp = longint'(mul_shr_u(p, SEMI_MINOR_01MM, 26));
        az = mul_shr_s(zq, longint'(SEMI_MAJOR_01MM), 26);
        dummy = rotate_to_axis(bp, az, dir);
        replay_unit(dir, ct, st);
        s3 = mul_shr_s(mul_shr_s(st, st, 60), st, 60);
        c3 = mul_shr_s(mul_shr_s(ct, ct, 60), ct, 60);
        num = zq + mul_shr_s(longint'(EPB_Q60), s3, 60);
        den = p - mul_shr_s(longint'(EA_Q60), c3, 60);
        if (den <= 0) begin
          if (num > 0) begin
            lat_rad = HALF_PI_Q60; cp = 0; sp = ONE_Q60;
          end else if (num < 0) begin
            lat_rad = -longint'(HALF_PI_Q60); cp = 0; sp = -longint'(ONE_Q60);
          end else begin
            lat_rad = 0; cp = ONE_Q60; sp = 0;
          end
        end else begin
          lat_rad = rotate_to_axis(den, num, dir);
          replay_unit(dir, cp, sp);
        end
        asp = sp < 0 ? -sp : sp;
        s2 = mul_shr_u(asp, asp, 60);
        c2s = mul_shr_u(C2_01, s2, 60);
        v = floor_sqrt((c2s < A2_01 ? A2_01 - c2s : 64'd0) << 12);
        aw = longint'((v << 13) / 5);
        hq = mul_shr_s(p, cp, 60) + mul_shr_s(zq, sp, 60) - aw;
        half = 64'sd1 << 19;
        h = hq >= 0 ? (hq + half) >>> 20 : -((-hq + half) >>> 20);
        lat = to_e7(lat_rad, LAT_LIM);
        lon = to_e7(lon, LON_LIM);
      end
      if (h > H_MAX) h = H_MAX;
      if (h < H_MIN) h = H_MIN;
      g.lat = lat[30:0];
      g.lon = lon[31:0];
      g.hgt = h[37:0];
      return g;
    endfunction

    function void note_point(longint x, longint y, longint z);
      pending_geo.push_back(convert(x, y, z));
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    endtask

    task check_result(geo_t got);
      geo_t want;
      if (pending_geo.size() == 0) begin
        report("unexpected beat", 0, 0);
        return;
      end
      want = pending_geo.pop_front();
      if (got.lat !== want.lat) report("latitude_e7", got.lat, want.lat);
      if (got.lon !== want.lon) report("longitude_e7", got.lon, want.lon);
      if (got.hgt !== want.hgt) report("height_mm", got.hgt, want.hgt);
      if (got.origin !== want.origin) report("at_origin", got.origin, want.origin);
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [37:0] ecef_x_mm_i = '0;
  logic signed [37:0] ecef_y_mm_i = '0;
  logic signed [37:0] ecef_z_mm_i = '0;
  logic               done_o;
  logic signed [30:0] latitude_e7_o;
  logic signed [31:0] longitude_e7_o;
  logic signed [37:0] height_mm_o;
  logic               at_origin_o;

  geo_scoreboard geo_sb = new();
  longint        cycles = 0;

  ecef_to_geodetic_top #(.ANGLE_ITERATIONS(N_ITER)) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .ecef_x_mm_i   (ecef_x_mm_i),
    .ecef_y_mm_i   (ecef_y_mm_i),
    .ecef_z_mm_i   (ecef_z_mm_i),
    .done_o        (done_o),
    .latitude_e7_o (latitude_e7_o),
    .longitude_e7_o(longitude_e7_o),
    .height_mm_o   (height_mm_o),
    .at_origin_o   (at_origin_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    geo_t got;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else if (rst_ni) begin
      if (start && !busy) geo_sb.note_point(ecef_x_mm_i, ecef_y_mm_i, ecef_z_mm_i);
      if (done_o) begin
        got.lat = latitude_e7_o;
        got.lon = longitude_e7_o;
        got.hgt = height_mm_o;
        got.origin = at_origin_o;
        geo_sb.check_result(got);
      end
    end
  end

  function automatic longint rand_span(longint span);
    longint unsigned r;
    r = {$urandom, $urandom};
    return longint'(r % longint'(2 * span + 1)) - span;
  endfunction

  function automatic longint rand_field();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return longint'({{26{r[37]}}, r[37:0]});
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_point(longint x, longint y, longint z, bit idle);
    int gap;
    start <= 1'b1;
    ecef_x_mm_i <= x[37:0];
    ecef_y_mm_i <= y[37:0];
    ecef_z_mm_i <= z[37:0];
    do @(posedge clk_i); while (busy);
    gap = idle ? pick_gap() : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    longint x, y, z;
    int mode;
    bit idle;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_point(0, 0, 0, 1);
    send_point(0, 0, 6356752300, 1);
    send_point(0, 0, -6356752300, 0);
    send_point(0, 0, FIELD_MAX, 0);
    send_point(0, 0, FIELD_MIN, 1);
    send_point(0, 0, 1, 0);
    send_point(6378137000, 0, 0, 0);
    send_point(-6378137000, 0, 0, 1);
    send_point(0, 6378137000, 0, 0);
    send_point(0, -6378137000, 0, 0);
    send_point(-1, 0, 0, 0);
    send_point(1, 0, 0, 1);
    send_point(0, -1, 0, 0);
    send_point(1, 1, -1000, 0);
    send_point(3, -2, 5000000, 0);
    send_point(FIELD_MAX, FIELD_MAX, FIELD_MAX, 1);
    send_point(FIELD_MIN, FIELD_MIN, FIELD_MIN, 0);
    send_point(FIELD_MIN, FIELD_MAX, 0, 0);
    send_point(FIELD_MAX, 0, FIELD_MIN, 0);
    send_point(-4510000000, -4510000000, 50000, 1);
    send_point(4000000000, -3000000000, 3500000000, 0);

    for (int n = 0; n < N_RANDOM; n++) begin
      mode = $urandom_range(0, 99);
      idle = ((n / 200) % 3) != 1;
      if (mode < 45) begin
        x = rand_span(SURF_SPAN); y = rand_span(SURF_SPAN); z = rand_span(SURF_SPAN);
      end else if (mode < 75) begin
        x = rand_field(); y = rand_field(); z = rand_field();
      end else if (mode < 85) begin
        x = rand_span(100000); y = rand_span(100000); z = rand_span(100000);
      end else if (mode < 92) begin
        x = 0; y = 0; z = rand_field();
      end else if (mode < 97) begin
        x = rand_field(); y = 0; z = rand_span(SURF_SPAN);
      end else begin
        x = 0; y = rand_field(); z = mode == 99 ? 0 : rand_span(SURF_SPAN);
      end
      send_point(x, y, z, idle);
    end
    start <= 1'b0;

    while (geo_sb.pending_geo.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);
    if (geo_sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
